// File: src/vertex_transform_4x4_unit_macros.svh
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Shared property forms for the vertex transform unit.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_UNIT_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_UNIT_MACROS_SVH

// same-cycle implication
`define VTX_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VTX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/vtx_pkg.sv
// ----------------------------------------------------------------------------
// Vertex transform package
// Widths, request codes and data types shared by the vertex transform unit.
// ----------------------------------------------------------------------------
package vtx_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int DIM       = 4;
   localparam int ELEMS     = DIM * DIM;
   localparam int IDX_BITS  = $clog2(ELEMS);
   localparam int PAIRS     = DIM / 2;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int PAIR_BITS = PROD_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS + 2;

   localparam logic REQ_LOAD      = 1'b0;
   localparam logic REQ_TRANSFORM = 1'b1;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [PAIR_BITS-1:0] pair_type;
   typedef logic signed [SUM_BITS-1:0]  sum_type;

   typedef word_type [ELEMS-1:0] matrix_type;
   typedef word_type [DIM-1:0]   vec_type;
   typedef sum_type  [DIM-1:0]   sums_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

endpackage

// File: src/vertex_transform_4x4_unit.sv
// ----------------------------------------------------------------------------
// Vertex transform unit
// Multiplies four-component signed Q16.16 vectors by a stored 4x4 matrix.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while req_ready is high (always so for
// loads). A load request writes one element of the column-major matrix (index
// row + 4*col) in the cycle it is accepted and returns nothing; every transform
// accepted after it sees the new value. A transform request returns one
// response through the pipeline: sixteen parallel 32x32 multipliers, a pair-add
// stage, a row-add stage and the shift/saturate output register. Each row sum is
// kept at full precision, shifted right by 16 with floor rounding and clipped to
// 32 bits; rsp_saturated flags any clipped component. Back-pressure on rsp_ready
// stalls only the stages that are full. The matrix resets to zero.
// ----------------------------------------------------------------------------
`include "vertex_transform_4x4_unit_macros.svh"

module vertex_transform_4x4_unit
   import vtx_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [IDX_BITS-1:0] req_elem_index,
   input  word_type            req_elem_value,
   input  word_type            req_vx,
   input  word_type            req_vy,
   input  word_type            req_vz,
   input  word_type            req_vw,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output word_type            rsp_rx,
   output word_type            rsp_ry,
   output word_type            rsp_rz,
   output word_type            rsp_rw,
   output logic                rsp_saturated
);

   matrix_type matrix;
   vec_type    vec;
   vec_type    result;
   sums_type   sums;
   logic       load_en;
   logic       mult_in_valid, mult_in_ready;
   logic       sums_valid, sums_ready;

   assign vec[0] = req_vx;
   assign vec[1] = req_vy;
   assign vec[2] = req_vz;
   assign vec[3] = req_vw;

   assign load_en       = req_valid && (req_type == REQ_LOAD);
   assign mult_in_valid = req_valid && (req_type == REQ_TRANSFORM);
   assign req_ready     = (req_type == REQ_LOAD) ? 1'b1 : mult_in_ready;

   vtx_matrix u_matrix (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load_en),
      .wr_index (req_elem_index),
      .wr_value (req_elem_value),
      .matrix   (matrix)
   );

   vtx_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mult_in_valid),
      .in_ready  (mult_in_ready),
      .matrix    (matrix),
      .vec       (vec),
      .out_valid (sums_valid),
      .out_ready (sums_ready),
      .sums      (sums)
   );

   vtx_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sums_valid),
      .in_ready  (sums_ready),
      .sums      (sums),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .result    (result),
      .saturated (rsp_saturated)
   );

   assign rsp_rx = result[0];
   assign rsp_ry = result[1];
   assign rsp_rz = result[2];
   assign rsp_rw = result[3];

   `VTX_ASSERT_NEXT(a_load_written, clock, reset, load_en, matrix[$past(req_elem_index)] == $past(req_elem_value), "load request not written to matrix")
   `VTX_ASSERT_SAME(a_sat_clipped, clock, reset, rsp_valid && rsp_saturated, rsp_rx == WORD_MAX || rsp_rx == WORD_MIN || rsp_ry == WORD_MAX || rsp_ry == WORD_MIN || rsp_rz == WORD_MAX || rsp_rz == WORD_MIN || rsp_rw == WORD_MAX || rsp_rw == WORD_MIN, "saturated flag without a clipped component")
   `VTX_ASSERT_NEXT(a_sums_hold, clock, reset, sums_valid && !sums_ready, sums_valid && $stable(sums), "stalled row sums changed")

endmodule

// File: src/vtx_matrix.sv
// ----------------------------------------------------------------------------
// Vertex transform matrix store
// Sixteen column-major matrix elements, written one at a time by load requests.
// ----------------------------------------------------------------------------
module vtx_matrix
   import vtx_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_index,
   input  word_type            wr_value,
   output matrix_type          matrix
);

   matrix_type store_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
      end else if (wr_en) begin
         store_ff[wr_index] <= wr_value;
      end
   end

   assign matrix = store_ff;

endmodule

// File: src/vtx_mult.sv
// ----------------------------------------------------------------------------
// Vertex transform product pipeline
// Three stages: sixteen products, pairwise sums, row sums at full precision.
// ----------------------------------------------------------------------------
module vtx_mult
   import vtx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  matrix_type matrix,
   input  vec_type    vec,
   output logic       out_valid,
   input  logic       out_ready,
   output sums_type   sums
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   prod_type [ELEMS-1:0]     prod_ff, prod_in;
   pair_type [2*DIM-1:0]     pair_ff, pair_in;
   sums_type                 sum_ff, sum_in;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // products: element row + DIM*col times component col
   for (genvar i = 0; i < ELEMS; i++) begin : g_prod
      assign prod_in[i] = prod_type'($signed(matrix[i])) * prod_type'($signed(vec[i / DIM]));
   end

   // pair sums: pair row*2+k adds columns 2k and 2k+1
   for (genvar r = 0; r < DIM; r++) begin : g_row
      for (genvar k = 0; k < PAIRS; k++) begin : g_pair
         assign pair_in[r*PAIRS+k] = pair_type'(prod_ff[r + DIM*(2*k)])
                                   + pair_type'(prod_ff[r + DIM*(2*k+1)]);
      end
      assign sum_in[r] = sum_type'(pair_ff[r*PAIRS]) + sum_type'(pair_ff[r*PAIRS+1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid)    prod_ff <= prod_in;
      if (s2_ready && s1_valid_ff) pair_ff <= pair_in;
      if (s3_ready && s2_valid_ff) sum_ff  <= sum_in;
   end

   assign out_valid = s3_valid_ff;
   assign sums      = sum_ff;

endmodule

// File: src/vtx_sat.sv
// ----------------------------------------------------------------------------
// Vertex transform output stage
// Shift each row sum down by the fraction width, saturate and register.
// ----------------------------------------------------------------------------
module vtx_sat
   import vtx_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  sums_type sums,
   output logic     out_valid,
   input  logic     out_ready,
   output vec_type  result,
   output logic     saturated
);

   localparam int TOP = FRAC_BITS + WORD_BITS - 1;

   logic    valid_ff;
   vec_type result_ff, result_in;
   logic    sat_ff, sat_in;
   logic [DIM-1:0] clip;

   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         clip[r] = (sums[r][SUM_BITS-1:TOP] != '0) && (sums[r][SUM_BITS-1:TOP] != '1);
         if (!clip[r]) begin
            result_in[r] = sums[r][TOP:FRAC_BITS];
         end else if (sums[r][SUM_BITS-1]) begin
            result_in[r] = WORD_MIN;
         end else begin
            result_in[r] = WORD_MAX;
         end
      end
      sat_in = |clip;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign result    = result_ff;
   assign saturated = sat_ff;

endmodule
